FILE: sv/ndeftlv_pkg.sv
// ----------------------------------------------------------------------------
// ndeftlv_pkg
// Shared types and constants for the NDEF TLV text extractor: parse phases,
// TLV byte codes and the layout of one queued result.
// ----------------------------------------------------------------------------
package ndeftlv_pkg;

  typedef enum logic [3:0] {
    PH_TAG,
    PH_LEN_NDEF,
    PH_LEN_OTHER,
    PH_LENH_NDEF,
    PH_LENH_OTHER,
    PH_LENL_NDEF,
    PH_LENL_OTHER,
    PH_SKIP,
    PH_HEADER,
    PH_LANG,
    PH_TEXT,
    PH_DONE
  } phase_t;

  localparam logic [7:0] TAG_NULL       = 8'h00;
  localparam logic [7:0] TAG_NDEF       = 8'h03;
  localparam logic [7:0] TAG_TERM       = 8'hFE;
  localparam logic [7:0] LEN_ESCAPE     = 8'hFF;
  localparam logic [7:0] PRINT_LOW      = 8'h20;
  localparam logic [7:0] PRINT_END      = 8'h7F;
  localparam logic [15:0] NDEF_MIN_LEN  = 16'd5;
  localparam logic [2:0] HDR_PLEN_OFS   = 3'd2;
  localparam logic [2:0] HDR_LANG_OFS   = 3'd4;

  // Result queue depth and pointer widths.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
    logic       text_found;
  } result_t;

endpackage

FILE: sv/ndef_tlv_text_extractor.sv
// ----------------------------------------------------------------------------
// ndef_tlv_text_extractor
// Walks the TLV blocks of tag user memory, one byte per word, and streams
// the printable characters of the first NDEF text record plus one end marker
// per frame.
// ----------------------------------------------------------------------------
// The block accepts one tag memory byte per clock cycle while in_tready is
// high. Each byte moves a small parser through the TLV structure; the
// results of that byte (a text character, an end marker, or both) are
// written into a four-entry result queue that feeds the output channel. A
// byte can give two results, and the input is ready while at least two queue
// entries are free, so with an output that is always ready the throughput is
// one byte per cycle, and each result is registered in the queue before it
// reaches the output. The only case that gives two results is a byte that
// gives a character and the end marker together, either the last byte of the
// text or a printable text byte that ends the frame; the queue absorbs that,
// and the output side sets the sustained rate when it stalls. Every frame,
// ended by in_tlast, produces exactly one end marker word (out_tlast high,
// data zero, out_tuser telling whether a text record header was parsed).
// Bytes after the end marker are dropped until the frame's last byte, after
// which the parser is back in its reset state.
module ndef_tlv_text_extractor
  import ndeftlv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // frame_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] text_char
  output logic       out_tlast,  // end_of_text
  output logic       out_tuser   // text_found
);

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic [15:0] blk_rem_r, blk_rem_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [2:0]  hoff_r, hoff_nxt;
  logic [7:0]  plen_r, plen_nxt;
  logic [5:0]  lang_r, lang_nxt;
  logic [7:0]  text_r, text_nxt;
  logic        seen_r, seen_nxt;

  // Per-byte decisions.
  logic        start_blk;
  logic        blk_ndef;
  logic [15:0] blk_len;
  logic        finish;
  logic        char_emit;
  logic        end_emit;
  logic        found_bit;
  logic [5:0]  lang_byte;

  // Result queue.
  result_t           q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [1:0]        push_n;
  result_t           slot0, slot1;
  logic              in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign lang_byte = in_tdata[5:0];

  // Next-state logic for one byte.
  always_comb begin
    phase_nxt   = phase_r;
    blk_rem_nxt = blk_rem_r;
    len_hi_nxt  = len_hi_r;
    hoff_nxt    = hoff_r;
    plen_nxt    = plen_r;
    lang_nxt    = lang_r;
    text_nxt    = text_r;
    seen_nxt    = seen_r;
    start_blk   = 1'b0;
    blk_ndef    = 1'b0;
    blk_len     = 16'd0;
    finish      = 1'b0;
    char_emit   = 1'b0;

    unique case (phase_r)
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      PH_LEN_NDEF, PH_LEN_OTHER: begin
        if (in_tdata == LEN_ESCAPE) begin
          phase_nxt = (phase_r == PH_LEN_NDEF) ? PH_LENH_NDEF : PH_LENH_OTHER;
        end else begin
          start_blk = 1'b1;
          blk_ndef  = (phase_r == PH_LEN_NDEF);
          blk_len   = {8'h00, in_tdata};
        end
      end
      PH_LENH_NDEF, PH_LENH_OTHER: begin
        len_hi_nxt = in_tdata;
        phase_nxt  = (phase_r == PH_LENH_NDEF) ? PH_LENL_NDEF : PH_LENL_OTHER;
      end
      PH_LENL_NDEF, PH_LENL_OTHER: begin
        start_blk = 1'b1;
        blk_ndef  = (phase_r == PH_LENL_NDEF);
        blk_len   = {len_hi_r, in_tdata};
      end
      PH_SKIP: begin
        blk_rem_nxt = blk_rem_r - 16'd1;
        if (blk_rem_nxt == 16'd0) begin
          phase_nxt = PH_TAG;
        end
      end
      PH_HEADER: begin
        if (hoff_r == HDR_PLEN_OFS) begin
          plen_nxt = in_tdata;
        end
        if (hoff_r == HDR_LANG_OFS) begin
          lang_nxt = lang_byte;
          seen_nxt = 1'b1;
          // Text length is payload - 1 - language; empty when payload <= language + 1.
          if ({1'b0, plen_r} <= {3'b000, lang_byte} + 9'd1) begin
            text_nxt = 8'd0;
            finish   = 1'b1;
          end else begin
            text_nxt  = plen_r - 8'd1 - {2'b00, lang_byte};
            phase_nxt = (lang_byte != 6'd0) ? PH_LANG : PH_TEXT;
          end
        end else begin
          hoff_nxt = hoff_r + 3'd1;
        end
      end
      PH_LANG: begin
        lang_nxt = lang_r - 6'd1;
        if (lang_nxt == 6'd0) begin
          phase_nxt = PH_TEXT;
        end
      end
      PH_TEXT: begin
        if (in_tdata >= PRINT_LOW && in_tdata < PRINT_END) begin
          char_emit = 1'b1;
        end
        text_nxt = text_r - 8'd1;
        if (text_nxt == 8'd0) begin
          finish = 1'b1;
        end
      end
      default: begin
        // Tag byte; any undefined phase code behaves the same way.
        if (in_tdata == TAG_TERM) begin
          finish = 1'b1;
        end else if (in_tdata == TAG_NULL) begin
          phase_nxt = PH_TAG;
        end else begin
          phase_nxt = (in_tdata == TAG_NDEF) ? PH_LEN_NDEF : PH_LEN_OTHER;
        end
      end
    endcase

    if (start_blk) begin
      if (blk_ndef && blk_len >= NDEF_MIN_LEN) begin
        phase_nxt = PH_HEADER;
        hoff_nxt  = 3'd0;
      end else if (blk_len == 16'd0) begin
        phase_nxt = PH_TAG;
      end else begin
        blk_rem_nxt = blk_len;
        phase_nxt   = PH_SKIP;
      end
    end

    if (finish) begin
      phase_nxt = PH_DONE;
    end

    // The end marker goes out once: on finish, or at frame end if not yet given.
    end_emit  = finish || (in_tlast && phase_nxt != PH_DONE);
    found_bit = seen_nxt;

    if (in_tlast) begin
      phase_nxt   = PH_TAG;
      blk_rem_nxt = 16'd0;
      len_hi_nxt  = 8'd0;
      hoff_nxt    = 3'd0;
      plen_nxt    = 8'd0;
      lang_nxt    = 6'd0;
      text_nxt    = 8'd0;
      seen_nxt    = 1'b0;
    end
  end

  // Result words for one byte: the character first, then the end marker.
  always_comb begin
    result_t char_res;
    result_t end_res;
    char_res.text_char   = in_tdata;
    char_res.end_of_text = 1'b0;
    char_res.text_found  = 1'b0;
    end_res.text_char    = 8'h00;
    end_res.end_of_text  = 1'b1;
    end_res.text_found   = found_bit;
    slot0  = char_emit ? char_res : end_res;
    slot1  = end_res;
    push_n = {1'b0, char_emit} + {1'b0, end_emit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TAG;
      blk_rem_r <= 16'd0;
      len_hi_r  <= 8'd0;
      hoff_r    <= 3'd0;
      plen_r    <= 8'd0;
      lang_r    <= 6'd0;
      text_r    <= 8'd0;
      seen_r    <= 1'b0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      blk_rem_r <= blk_rem_nxt;
      len_hi_r  <= len_hi_nxt;
      hoff_r    <= hoff_nxt;
      plen_r    <= plen_nxt;
      lang_r    <= lang_nxt;
      text_r    <= text_nxt;
      seen_r    <= seen_nxt;
    end
  end

  // Result queue: up to two writes per accepted byte, one read per cycle while the output is ready.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (push_n != 2'd0) begin
        q_mem[wr_ptr_r] <= slot0;
      end
      if (push_n == 2'd2) begin
        q_mem[wr_ptr_r + QPTR_W'(1)] <= slot1;
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc) begin
      count_nxt = count_nxt + {1'b0, push_n};
    end
    if (out_acc) begin
      count_nxt = count_nxt - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + push_n[QPTR_W-1:0];
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Room for the worst case of two results per byte.
  assign in_tready  = (count_r <= QCNT_W'(QDEPTH - 2));
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = q_mem[rd_ptr_r].text_char;
  assign out_tlast  = q_mem[rd_ptr_r].end_of_text;
  assign out_tuser  = q_mem[rd_ptr_r].text_found;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_frame_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> phase_r == PH_TAG && !seen_r)
    else $error("parser not back at tag phase after frame end");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == 8'h00)
    else $error("end marker carries a character");

  a_char_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |->
      out_tdata >= PRINT_LOW && out_tdata < PRINT_END && !out_tuser)
    else $error("character result is not printable or has found flag");
`endif

endmodule
